FILE: rtl/core/pfwsr_pkg.sv
// ----------------------------------------------------------------------------
// pfwsr_pkg
// Shared types and constants for the wide printf format specifier rewriter.
// ----------------------------------------------------------------------------
package pfwsr_pkg;

	localparam int UNIT_W = 21;

	typedef logic [UNIT_W-1:0] unit_t;

	// specifier phase codes
	localparam logic [2:0] PH_TEXT  = 3'd0;
	localparam logic [2:0] PH_FLAGS = 3'd1;
	localparam logic [2:0] PH_WIDTH = 3'd2;
	localparam logic [2:0] PH_PREC  = 3'd3;
	localparam logic [2:0] PH_MODS  = 3'd4;
	localparam logic [2:0] PH_WHELD = 3'd5;

	// character codes
	localparam unit_t CH_NUL     = 21'h000000;
	localparam unit_t CH_SPACE   = 21'h000020;
	localparam unit_t CH_HASH    = 21'h000023;
	localparam unit_t CH_PERCENT = 21'h000025;
	localparam unit_t CH_APOS    = 21'h000027;
	localparam unit_t CH_PLUS    = 21'h00002B;
	localparam unit_t CH_MINUS   = 21'h00002D;
	localparam unit_t CH_DOT     = 21'h00002E;
	localparam unit_t CH_ZERO    = 21'h000030;
	localparam unit_t CH_NINE    = 21'h000039;
	localparam unit_t CH_UC_C    = 21'h000043;
	localparam unit_t CH_UC_I    = 21'h000049;
	localparam unit_t CH_UC_L    = 21'h00004C;
	localparam unit_t CH_UC_S    = 21'h000053;
	localparam unit_t CH_LC_C    = 21'h000063;
	localparam unit_t CH_LC_H    = 21'h000068;
	localparam unit_t CH_LC_L    = 21'h00006C;
	localparam unit_t CH_LC_S    = 21'h000073;
	localparam unit_t CH_LC_W    = 21'h000077;

	// decode result for one unit
	typedef struct packed {
		logic [1:0] cnt;
		unit_t      r0;
		unit_t      r1;
		logic [2:0] ph_next;
	} dec_t;

endpackage

FILE: rtl/core/pfwsr_decode.sv
// ----------------------------------------------------------------------------
// pfwsr_decode
// Per-unit rewrite decision: results for one code unit and the next phase.
// ----------------------------------------------------------------------------
module pfwsr_decode (
	input  logic [2:0]      phase,
	input  pfwsr_pkg::unit_t unit,
	output pfwsr_pkg::dec_t  dec
);
	import pfwsr_pkg::*;

	logic is_flag;
	logic is_digit;
	logic is_mod;
	logic is_str;
	unit_t swapped;
	dec_t  mod_start;

	assign is_flag = (unit == CH_MINUS) || (unit == CH_PLUS) || (unit == CH_SPACE) ||
		(unit == CH_HASH) || (unit == CH_APOS) || (unit == CH_ZERO);
	assign is_digit = (unit >= CH_ZERO) && (unit <= CH_NINE);
	assign is_mod = (unit == CH_LC_H) || (unit == CH_LC_L) || (unit == CH_UC_L) ||
		(unit == CH_LC_W) || (unit == CH_UC_I);
	assign is_str = (unit == CH_LC_S) || (unit == CH_UC_S) ||
		(unit == CH_LC_C) || (unit == CH_UC_C);

	always_comb begin
		case (unit)
			CH_LC_S: swapped = CH_UC_S;
			CH_UC_S: swapped = CH_LC_S;
			CH_LC_C: swapped = CH_UC_C;
			CH_UC_C: swapped = CH_LC_C;
			default: swapped = unit;
		endcase
	end

	// unit at the modifier position
	always_comb begin
		mod_start.r1 = CH_NUL;
		if (unit == CH_LC_W) begin
			mod_start.cnt     = 2'd0;
			mod_start.r0      = unit;
			mod_start.ph_next = PH_WHELD;
		end else if (is_mod) begin
			mod_start.cnt     = 2'd1;
			mod_start.r0      = unit;
			mod_start.ph_next = PH_MODS;
		end else begin
			mod_start.cnt     = 2'd1;
			mod_start.r0      = swapped;
			mod_start.ph_next = PH_TEXT;
		end
	end

	always_comb begin
		dec.cnt     = 2'd1;
		dec.r0      = unit;
		dec.r1      = CH_NUL;
		dec.ph_next = phase;
		if (unit == CH_NUL) begin
			// terminator flushes a held 'w'
			if (phase == PH_WHELD) begin
				dec.cnt = 2'd2;
				dec.r0  = CH_LC_W;
			end
			dec.ph_next = PH_TEXT;
		end else begin
			case (phase)
				PH_FLAGS, PH_WIDTH: begin
					if (phase == PH_FLAGS && is_flag) begin
						dec.ph_next = PH_FLAGS;
					end else if (is_digit) begin
						dec.ph_next = PH_WIDTH;
					end else if (unit == CH_DOT) begin
						dec.ph_next = PH_PREC;
					end else begin
						dec = mod_start;
					end
				end
				PH_PREC: begin
					if (!is_digit) begin
						dec = mod_start;
					end
				end
				PH_MODS: begin
					dec.ph_next = is_mod ? PH_MODS : PH_TEXT;
				end
				PH_WHELD: begin
					dec.cnt     = 2'd2;
					dec.r0      = is_str ? CH_LC_L : CH_LC_W;
					dec.r1      = unit;
					dec.ph_next = PH_TEXT;
				end
				default: begin
					dec.ph_next = (unit == CH_PERCENT) ? PH_FLAGS : PH_TEXT;
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/printf_format_wide_specifier_rewriter.sv
// ----------------------------------------------------------------------------
// printf_format_wide_specifier_rewriter
// Rewrites a wide printf format stream: swaps s/S and c/C in bare specifiers
// and turns a 'w' size modifier into 'l' ahead of string conversions.
// ----------------------------------------------------------------------------
//  channel | signals                        | transaction
//  --------+--------------------------------+-------------------------------
//  input   | in_valid, in_stall, code_unit  | one format code unit
//  output  | out_valid, out_stall,          | one rewritten unit; last_of_run
//          | out_unit, last_of_run          | marks the last one per input
//
//  One input unit per cycle while in_stall is low; a unit that yields two
//  results (flushed or resolved 'w') holds the two-entry output buffer until both are taken.
//  An input unit is registered in the input stage, then decoded into the output buffer.
//  Reset clears the input stage valid flag, the output buffer count and the phase.
//  An output stall backs up into in_stall only once the input stage is full.
// ----------------------------------------------------------------------------
module printf_format_wide_specifier_rewriter (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  pfwsr_pkg::unit_t code_unit,
	output logic             out_valid,
	input  logic             out_stall,
	output pfwsr_pkg::unit_t out_unit,
	output logic             last_of_run
);
	import pfwsr_pkg::*;

	logic       valid_s1;
	unit_t      unit_s1;
	logic [2:0] phase_q;
	logic [1:0] cnt_q;
	unit_t      a_unit_q;
	logic       a_last_q;
	unit_t      b_unit_q;
	dec_t       dec;
	logic       out_acc;
	logic       proc;

	pfwsr_decode u_decode (
		.phase (phase_q),
		.unit  (unit_s1),
		.dec   (dec)
	);

	assign out_valid   = (cnt_q != 2'd0);
	assign out_unit    = a_unit_q;
	assign last_of_run = a_last_q;
	assign out_acc     = out_valid && !out_stall;
	// buffer is free now or empties this cycle
	assign proc        = valid_s1 && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && !out_stall));
	assign in_stall    = valid_s1 && !proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			unit_s1 <= code_unit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TEXT;
			cnt_q   <= 2'd0;
		end else if (proc) begin
			phase_q <= dec.ph_next;
			cnt_q   <= dec.cnt;
		end else if (out_acc) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			a_unit_q <= dec.r0;
			a_last_q <= (dec.cnt == 2'd1);
			b_unit_q <= dec.r1;
		end else if (out_acc && cnt_q == 2'd2) begin
			a_unit_q <= b_unit_q;
			a_last_q <= 1'b1;
		end
	end

endmodule

FILE: verif/tb_printf_format_wide_specifier_rewriter.sv
// ----------------------------------------------------------------------------
// tb_printf_format_wide_specifier_rewriter
// Self-checking bench for the wide printf format rewriter. A short directed
// table walks the specifier phases, the s/S and c/C swap, held 'w' and the
// terminator. Random format strings with broken sequences and raw units
// follow. Every output is checked against the directed table or an in-bench
// predictor, with random idle gaps on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_printf_format_wide_specifier_rewriter;
	import pfwsr_pkg::*;

	localparam int    N_ITEMS     = 1350;
	localparam int    N_DIRECTED  = 25;
	localparam int    CYCLE_LIMIT = 400000;
	localparam int    HOLD_CYCLES = 400;
	localparam int    DRAIN_CYCLES = 16;
	localparam unit_t UNIT_MAX    = '1;
	localparam unit_t CH_UC_A     = 21'h000041;
	localparam unit_t CH_LC_D     = 21'h000064;
	localparam unit_t CH_LC_F     = 21'h000066;
	localparam unit_t CH_LC_X     = 21'h000078;

	typedef struct {
		unit_t      cu;
		bit         typed;
		logic [1:0] cnt;
		unit_t      e0;
		unit_t      e1;
	} stim_row_t;

	typedef struct {
		unit_t unit;
		logic  last;
	} out_entry_t;

	logic  clk = 1'b0;
	logic  arst_n;
	logic  in_valid;
	logic  in_stall;
	unit_t code_unit;
	logic  out_valid;
	logic  out_stall;
	unit_t out_unit;
	logic  last_of_run;

	stim_row_t  directed_tbl[N_DIRECTED];
	stim_row_t  format_stream[$];
	out_entry_t pending_units[$];
	unit_t      flag_pool[6];
	unit_t      mod_pool[4];
	unit_t      conv_pool[8];
	logic [2:0] spec_phase;
	int         errors;
	int         n_results;
	int         cycle_cnt;

	printf_format_wide_specifier_rewriter DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.code_unit   (code_unit),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_unit    (out_unit),
		.last_of_run (last_of_run)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// expected rewrite of one unit in the given phase
	function automatic dec_t rewrite_unit(unit_t cu, logic [2:0] ph);
		dec_t d;
		logic at_mod;
		d = '0;
		at_mod = 1'b0;
		d.ph_next = PH_TEXT;
		if (cu == CH_NUL) begin
			d.cnt = 2'd1;
			d.r0 = CH_NUL;
			if (ph == PH_WHELD) begin
				d.cnt = 2'd2;
				d.r0 = CH_LC_W;
				d.r1 = CH_NUL;
			end
		end else begin
			case (ph)
				PH_FLAGS, PH_WIDTH: begin
					if (ph == PH_FLAGS && cu inside {CH_MINUS, CH_PLUS, CH_SPACE, CH_HASH,
							CH_APOS, CH_ZERO}) begin
						d.cnt = 2'd1;
						d.r0 = cu;
						d.ph_next = PH_FLAGS;
					end else if (cu >= CH_ZERO && cu <= CH_NINE) begin
						d.cnt = 2'd1;
						d.r0 = cu;
						d.ph_next = PH_WIDTH;
					end else if (cu == CH_DOT) begin
						d.cnt = 2'd1;
						d.r0 = cu;
						d.ph_next = PH_PREC;
					end else begin
						at_mod = 1'b1;
					end
				end
				PH_PREC: begin
					if (cu >= CH_ZERO && cu <= CH_NINE) begin
						d.cnt = 2'd1;
						d.r0 = cu;
						d.ph_next = PH_PREC;
					end else begin
						at_mod = 1'b1;
					end
				end
				PH_MODS: begin
					d.cnt = 2'd1;
					d.r0 = cu;
					d.ph_next = (cu inside {CH_LC_H, CH_LC_L, CH_UC_L, CH_LC_W, CH_UC_I}) ?
						PH_MODS : PH_TEXT;
				end
				PH_WHELD: begin
					d.cnt = 2'd2;
					d.r0 = (cu inside {CH_LC_S, CH_UC_S, CH_LC_C, CH_UC_C}) ? CH_LC_L : CH_LC_W;
					d.r1 = cu;
				end
				default: begin
					d.cnt = 2'd1;
					d.r0 = cu;
					d.ph_next = (cu == CH_PERCENT) ? PH_FLAGS : PH_TEXT;
				end
			endcase
			if (at_mod) begin
				if (cu == CH_LC_W) begin
					d.ph_next = PH_WHELD;
				end else if (cu inside {CH_LC_H, CH_LC_L, CH_UC_L, CH_UC_I}) begin
					d.cnt = 2'd1;
					d.r0 = cu;
					d.ph_next = PH_MODS;
				end else begin
					d.cnt = 2'd1;
					case (cu)
						CH_LC_S: d.r0 = CH_UC_S;
						CH_UC_S: d.r0 = CH_LC_S;
						CH_LC_C: d.r0 = CH_UC_C;
						CH_UC_C: d.r0 = CH_LC_C;
						default: d.r0 = cu;
					endcase
				end
			end
		end
		return d;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void add_unit(unit_t cu);
		format_stream.push_back('{cu, 1'b0, 2'd0, CH_NUL, CH_NUL});
	endfunction

	function automatic unit_t raw_unit();
		return unit_t'($urandom_range(0, 32'h1FFFFF));
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("ERROR %0t: %s: got %h want %h", $time, what, got, want);
		errors++;
	endtask

	// build the stream: directed table first, then random format strings
	task automatic build_stream();
		int sel;
		int k;
		directed_tbl = '{
			'{CH_UC_A,    1'b1, 2'd1, CH_UC_A,  CH_NUL},
			'{UNIT_MAX,   1'b1, 2'd1, UNIT_MAX, CH_NUL},
			'{CH_NUL,     1'b1, 2'd1, CH_NUL,   CH_NUL},
			'{CH_PERCENT, 1'b1, 2'd1, CH_PERCENT, CH_NUL},
			'{CH_LC_S,    1'b1, 2'd1, CH_UC_S,  CH_NUL},
			'{CH_PERCENT, 1'b0, 2'd0, CH_NUL,   CH_NUL},
			'{CH_MINUS,   1'b0, 2'd0, CH_NUL,   CH_NUL},
			'{CH_ZERO,    1'b0, 2'd0, CH_NUL,   CH_NUL},
			'{CH_NINE,    1'b0, 2'd0, CH_NUL,   CH_NUL},
			'{CH_DOT,     1'b0, 2'd0, CH_NUL,   CH_NUL},
			'{CH_ZERO,    1'b0, 2'd0, CH_NUL,   CH_NUL},
			'{CH_LC_W,    1'b1, 2'd0, CH_NUL,   CH_NUL},
			'{CH_UC_S,    1'b1, 2'd2, CH_LC_L,  CH_UC_S},
			'{CH_PERCENT, 1'b0, 2'd0, CH_NUL,   CH_NUL},
			'{CH_LC_W,    1'b1, 2'd0, CH_NUL,   CH_NUL},
			'{CH_NUL,     1'b1, 2'd2, CH_LC_W,  CH_NUL},
			'{CH_PERCENT, 1'b0, 2'd0, CH_NUL,   CH_NUL},
			'{CH_LC_H,    1'b0, 2'd0, CH_NUL,   CH_NUL},
			'{CH_UC_I,    1'b0, 2'd0, CH_NUL,   CH_NUL},
			'{CH_LC_C,    1'b0, 2'd0, CH_NUL,   CH_NUL},
			'{CH_PERCENT, 1'b0, 2'd0, CH_NUL,   CH_NUL},
			'{CH_LC_W,    1'b0, 2'd0, CH_NUL,   CH_NUL},
			'{CH_LC_D,    1'b1, 2'd2, CH_LC_W,  CH_LC_D},
			'{CH_PERCENT, 1'b0, 2'd0, CH_NUL,   CH_NUL},
			'{CH_UC_C,    1'b1, 2'd1, CH_LC_C,  CH_NUL}
		};
		flag_pool = '{CH_MINUS, CH_PLUS, CH_SPACE, CH_HASH, CH_APOS, CH_ZERO};
		mod_pool  = '{CH_LC_H, CH_LC_L, CH_UC_L, CH_UC_I};
		conv_pool = '{CH_LC_S, CH_UC_S, CH_LC_C, CH_UC_C, CH_LC_D, CH_LC_X, CH_LC_F,
			CH_PERCENT};
		foreach (directed_tbl[i])
			format_stream.push_back(directed_tbl[i]);

		while (format_stream.size() < N_ITEMS) begin
			sel = $urandom_range(0, 99);
			if (sel < 60) begin
				add_unit(CH_PERCENT);
				repeat ($urandom_range(0, 2))
					add_unit(flag_pool[$urandom_range(0, 5)]);
				if ($urandom_range(0, 1))
					repeat ($urandom_range(1, 2))
						add_unit(CH_ZERO + unit_t'($urandom_range(0, 9)));
				if ($urandom_range(0, 2) == 0) begin
					add_unit(CH_DOT);
					repeat ($urandom_range(0, 2))
						add_unit(CH_ZERO + unit_t'($urandom_range(0, 9)));
				end
				k = $urandom_range(0, 3);
				if (k == 1)
					add_unit(CH_LC_W);
				else if (k == 2)
					add_unit(mod_pool[$urandom_range(0, 3)]);
				else if (k == 3) begin
					add_unit(mod_pool[$urandom_range(0, 3)]);
					add_unit(mod_pool[$urandom_range(0, 3)]);
				end
				k = $urandom_range(0, 9);
				if (k < 5)
					add_unit(conv_pool[$urandom_range(0, 3)]);
				else if (k < 8)
					add_unit(conv_pool[$urandom_range(4, 7)]);
				else if (k == 8)
					// a modifier letter in the conversion slot
					add_unit($urandom_range(0, 1) ? CH_LC_W : mod_pool[$urandom_range(0, 3)]);
				else
					add_unit($urandom_range(0, 1) ? CH_NUL : raw_unit());
			end else if (sel < 70) begin
				add_unit(CH_NUL);
			end else if (sel < 85) begin
				repeat ($urandom_range(1, 4))
					add_unit(unit_t'($urandom_range(32'h20, 32'h7E)));
			end else begin
				repeat ($urandom_range(1, 3))
					add_unit(raw_unit());
			end
		end
	endtask

	// sender
	initial begin
		stim_row_t row;
		dec_t      d;
		int        gap;
		arst_n = 1'b0;
		in_valid = 1'b0;
		code_unit = CH_NUL;
		errors = 0;
		n_results = 0;
		spec_phase = PH_TEXT;
		build_stream();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < format_stream.size(); i++) begin
			row = format_stream[i];
			gap = ((i / 100) % 4 == 3) ? 0 : idle_len();
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			in_valid <= 1'b1;
			code_unit <= row.cu;
			@(posedge clk);
			while (in_stall)
				@(posedge clk);
			// transaction taken at this edge
			d = rewrite_unit(row.cu, spec_phase);
			spec_phase = d.ph_next;
			if (row.typed) begin
				d.cnt = row.cnt;
				d.r0 = row.e0;
				d.r1 = row.e1;
			end
			if (d.cnt != 2'd0)
				pending_units.push_back('{d.r0, d.cnt == 2'd1});
			if (d.cnt == 2'd2)
				pending_units.push_back('{d.r1, 1'b1});
		end
		in_valid <= 1'b0;

		while (pending_units.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// receiver stall pattern
	initial begin
		bit held_off;
		int stall_len;
		int run_len;
		held_off = 1'b0;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held_off && n_results >= 500) begin
				// long hold-off so the block backs up into its input
				held_off = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			stall_len = idle_len();
			run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120) :
				$urandom_range(1, 12);
			if (stall_len > 0) begin
				out_stall <= 1'b1;
				repeat (stall_len) @(posedge clk);
			end
			out_stall <= 1'b0;
			repeat (run_len) @(posedge clk);
		end
	end

	always @(posedge clk) begin : result_check
		out_entry_t want;
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (pending_units.size() == 0) begin
				report_mismatch("result with none expected", 32'(out_unit), 32'(CH_NUL));
			end else begin
				want = pending_units.pop_front();
				if (out_unit !== want.unit)
					report_mismatch("out_unit", 32'(out_unit), 32'(want.unit));
				if (last_of_run !== want.last)
					report_mismatch("last_of_run", 32'(last_of_run), 32'(want.last));
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial cycle_cnt = 0;

endmodule
